// File: rtl/core/text_cursor_controller_macros.svh
// Shared assertion macros for the cursor controller.
`ifndef TEXT_CURSOR_CONTROLLER_MACROS_SVH
`define TEXT_CURSOR_CONTROLLER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define TCC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("cursor controller check failed");

// Next-cycle implication, checked out of reset.
`define TCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("cursor controller check failed");

`endif

// File: rtl/core/tcc_pkg.sv
package tcc_pkg;

	localparam int QUEUE_DEPTH_DEF = 2;

	localparam logic [1:0] OP_CHAR = 2'd0;
	localparam logic [1:0] OP_SET  = 2'd1;
	localparam logic [1:0] OP_MOVX = 2'd2;
	localparam logic [1:0] OP_MOVY = 2'd3;

	localparam logic [6:0] CH_NUL = 7'h00;
	localparam logic [6:0] CH_BS  = 7'h08;
	localparam logic [6:0] CH_TAB = 7'h09;
	localparam logic [6:0] CH_LF  = 7'h0A;
	localparam logic [6:0] CH_VT  = 7'h0B;
	localparam logic [6:0] CH_FF  = 7'h0C;
	localparam logic [6:0] CH_CR  = 7'h0D;
	localparam logic [6:0] CH_DEL = 7'h7F;

	localparam logic [6:0]  GLYPH_ERASE = 7'h20;
	localparam logic [7:0]  LEFT_EDGE   = 8'd1;
	localparam logic [10:0] TOP_EDGE    = 11'd8;
	localparam logic [10:0] ROW_PIXELS  = 11'd8;
	localparam logic [10:0] BOTTOM_MARGIN = 11'd16;
	localparam logic [7:0]  TAB_ADVANCE = 8'd4;

	localparam logic [7:0]  RESET_COLUMN = 8'd25;
	localparam logic [10:0] RESET_LINE   = 11'd32;
	localparam logic [7:0]  RESET_BYTES_PER_LINE = 8'd40;
	localparam logic [10:0] RESET_SCROLL_LIMIT   = 11'd224;

	localparam logic REG_BYTES_PER_LINE = 1'b0;
	localparam logic REG_SCREEN_LINES   = 1'b1;

	typedef enum logic [3:0] {
		CMD_NOP,
		CMD_PRINT,
		CMD_BS,
		CMD_TAB,
		CMD_NL,
		CMD_VT,
		CMD_FF,
		CMD_DEL,
		CMD_SET,
		CMD_MOVX,
		CMD_MOVY
	} cmd_kind_t;

	typedef struct packed {
		logic [1:0]        opcode;
		logic [6:0]        char_code;
		logic [7:0]        set_column;
		logic [7:0]        set_row;
		logic signed [7:0] move_offset;
	} in_t;

	typedef struct packed {
		logic        draw_valid;
		logic [7:0]  draw_column;
		logic [10:0] draw_line;
		logic [6:0]  draw_glyph;
		logic        scroll_up;
		logic [7:0]  cursor_column;
		logic [10:0] cursor_line;
	} out_t;

	// column holds the set column or X offset, line the set line or scaled Y offset
	typedef struct packed {
		cmd_kind_t   kind;
		logic [6:0]  glyph;
		logic [7:0]  column;
		logic [10:0] line;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

// File: rtl/core/tcc_front.sv
module tcc_front (
	input  tcc_pkg::in_t  item,
	output tcc_pkg::cmd_t cmd
);

	always_comb begin
		cmd.kind   = tcc_pkg::CMD_NOP;
		cmd.glyph  = item.char_code;
		cmd.column = item.set_column;
		cmd.line   = {item.set_row, 3'b000};
		case (item.opcode)
			tcc_pkg::OP_SET: begin
				cmd.kind = tcc_pkg::CMD_SET;
			end
			tcc_pkg::OP_MOVX: begin
				cmd.kind   = tcc_pkg::CMD_MOVX;
				cmd.column = item.move_offset;
			end
			tcc_pkg::OP_MOVY: begin
				// offset times eight, modulo the line width
				cmd.kind = tcc_pkg::CMD_MOVY;
				cmd.line = {item.move_offset, 3'b000};
			end
			default: begin
				case (item.char_code)
					tcc_pkg::CH_NUL: cmd.kind = tcc_pkg::CMD_NOP;
					tcc_pkg::CH_BS:  cmd.kind = tcc_pkg::CMD_BS;
					tcc_pkg::CH_TAB: cmd.kind = tcc_pkg::CMD_TAB;
					tcc_pkg::CH_LF:  cmd.kind = tcc_pkg::CMD_NL;
					tcc_pkg::CH_CR:  cmd.kind = tcc_pkg::CMD_NL;
					tcc_pkg::CH_VT:  cmd.kind = tcc_pkg::CMD_VT;
					tcc_pkg::CH_FF:  cmd.kind = tcc_pkg::CMD_FF;
					tcc_pkg::CH_DEL: cmd.kind = tcc_pkg::CMD_DEL;
					default:         cmd.kind = tcc_pkg::CMD_PRINT;
				endcase
			end
		endcase
	end

endmodule

// File: rtl/core/tcc_queue.sv
module tcc_queue #(
	parameter int DEPTH = tcc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  tcc_pkg::cmd_t        wr_cmd,
	input  logic                 rd_en,
	output tcc_pkg::cmd_t        rd_cmd,
	output tcc_pkg::q_status_t   status
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	tcc_pkg::cmd_t    mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign status.full  = (count_q == CNT_W'(DEPTH));
	assign status.empty = (count_q == '0);
	assign do_wr  = wr_en && !status.full;
	assign do_rd  = rd_en && !status.empty;
	assign rd_cmd = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/core/tcc_back.sv
module tcc_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	input  tcc_pkg::cmd_t cmd,
	output logic          cmd_ready,
	input  logic          cfg_we,
	input  logic          cfg_index,
	input  logic [10:0]   cfg_data,
	output logic          res_valid,
	output tcc_pkg::out_t res,
	input  logic          pop
);

	logic [7:0]    col_q;
	logic [10:0]   line_q;
	logic [7:0]    bpl_q;
	logic [10:0]   limit_q;
	logic          res_valid_q;
	tcc_pkg::out_t res_q;

	logic [7:0]    adv_sum;
	logic          adv_wrap;
	logic [7:0]    adv_col;
	logic [10:0]   adv_line;
	logic [7:0]    nxt_col;
	logic [10:0]   pre_line;
	logic [10:0]   nxt_line;
	logic          chk;
	logic          scroll;
	logic          fire;
	tcc_pkg::out_t nxt_res;

	assign cmd_ready = !res_valid_q || pop;
	assign fire      = cmd_valid && cmd_ready;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// tab steps three then advances once: one add of four
	assign adv_sum  = col_q + ((cmd.kind == tcc_pkg::CMD_TAB) ? tcc_pkg::TAB_ADVANCE : 8'd1);
	assign adv_wrap = (adv_sum >= bpl_q);
	assign adv_col  = adv_wrap ? tcc_pkg::LEFT_EDGE : adv_sum;
	assign adv_line = adv_wrap ? line_q + tcc_pkg::ROW_PIXELS : line_q;

	always_comb begin
		nxt_col  = col_q;
		pre_line = line_q;
		chk      = 1'b0;
		nxt_res  = '0;
		case (cmd.kind)
			tcc_pkg::CMD_PRINT: begin
				nxt_res.draw_valid  = 1'b1;
				nxt_res.draw_column = col_q;
				nxt_res.draw_line   = line_q;
				nxt_res.draw_glyph  = cmd.glyph;
				nxt_col  = adv_col;
				pre_line = adv_line;
				chk      = 1'b1;
			end
			tcc_pkg::CMD_TAB: begin
				nxt_col  = adv_col;
				pre_line = adv_line;
				chk      = 1'b1;
			end
			tcc_pkg::CMD_NL: begin
				nxt_col  = tcc_pkg::LEFT_EDGE;
				pre_line = line_q + tcc_pkg::ROW_PIXELS;
				chk      = 1'b1;
			end
			tcc_pkg::CMD_VT: begin
				pre_line = line_q + tcc_pkg::ROW_PIXELS;
				chk      = 1'b1;
			end
			tcc_pkg::CMD_FF: begin
				nxt_col  = tcc_pkg::LEFT_EDGE;
				pre_line = tcc_pkg::TOP_EDGE;
			end
			tcc_pkg::CMD_BS: begin
				// hold at column zero
				nxt_col = (col_q == 8'd0) ? 8'd0 : col_q - 8'd1;
				nxt_res.draw_valid  = 1'b1;
				nxt_res.draw_column = nxt_col;
				nxt_res.draw_line   = line_q;
				nxt_res.draw_glyph  = tcc_pkg::GLYPH_ERASE;
			end
			tcc_pkg::CMD_DEL: begin
				nxt_col = col_q + 8'd1;
				nxt_res.draw_valid  = 1'b1;
				nxt_res.draw_column = nxt_col;
				nxt_res.draw_line   = line_q;
				nxt_res.draw_glyph  = tcc_pkg::GLYPH_ERASE;
			end
			tcc_pkg::CMD_SET: begin
				nxt_col  = cmd.column;
				pre_line = cmd.line;
			end
			tcc_pkg::CMD_MOVX: begin
				nxt_col = col_q + cmd.column;
			end
			tcc_pkg::CMD_MOVY: begin
				pre_line = line_q + cmd.line;
			end
			default: begin
			end
		endcase
		scroll   = chk && (pre_line >= limit_q);
		nxt_line = scroll ? pre_line - tcc_pkg::ROW_PIXELS : pre_line;
		nxt_res.scroll_up     = scroll;
		nxt_res.cursor_column = nxt_col;
		nxt_res.cursor_line   = nxt_line;
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= nxt_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= tcc_pkg::RESET_COLUMN;
			line_q      <= tcc_pkg::RESET_LINE;
			bpl_q       <= tcc_pkg::RESET_BYTES_PER_LINE;
			limit_q     <= tcc_pkg::RESET_SCROLL_LIMIT;
			res_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				col_q       <= nxt_col;
				line_q      <= nxt_line;
				res_valid_q <= 1'b1;
			end else if (pop) begin
				res_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				case (cfg_index)
					tcc_pkg::REG_BYTES_PER_LINE: begin
						bpl_q <= cfg_data[7:0];
					end
					tcc_pkg::REG_SCREEN_LINES: begin
						// store the scroll threshold, held at zero on tiny screens
						limit_q <= (cfg_data >= tcc_pkg::BOTTOM_MARGIN) ?
							cfg_data - tcc_pkg::BOTTOM_MARGIN : 11'd0;
					end
					default: begin
					end
				endcase
			end
		end
	end

endmodule

// File: rtl/core/text_cursor_controller.sv
// channel   | handshake                  | beat
// ----------+----------------------------+---------------------------------
// input     | push / full                | item   (opcode, char, set, move)
// result    | pop / empty                | result (draw request, scroll, cursor)
// config    | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// One item per cycle sustained while results are popped; a beat passes the queue, then the result register.
// The queue between decode and execute takes pushes while a result waits for pop, until it is full.
// Cursor update (one add, one compare, one scroll compare) is the combinational loop on the cursor registers.
// Reset restores the cursor to column 25, line 32 and the screen registers to 40 and a scroll limit of 224.
// cfg_ready is always high; config beats are taken at once.
`include "text_cursor_controller_macros.svh"

module text_cursor_controller #(
	parameter int QUEUE_DEPTH = tcc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  tcc_pkg::in_t  item,
	output logic          empty,
	input  logic          pop,
	output tcc_pkg::out_t result,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic          cfg_index,
	input  logic [10:0]   cfg_data
);

	tcc_pkg::cmd_t      dec_cmd;
	tcc_pkg::cmd_t      q_cmd;
	tcc_pkg::q_status_t q_stat;
	logic               back_ready;
	logic               res_valid;
	logic               draw_clear;

	assign cfg_ready = 1'b1;
	assign full      = q_stat.full;
	assign empty     = !res_valid;

	assign draw_clear = (result.draw_column == 8'd0) && (result.draw_line == 11'd0) &&
		(result.draw_glyph == 7'd0);

	tcc_front u_front (
		.item (item),
		.cmd  (dec_cmd)
	);

	tcc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (push),
		.wr_cmd (dec_cmd),
		.rd_en  (back_ready),
		.rd_cmd (q_cmd),
		.status (q_stat)
	);

	tcc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (!q_stat.empty),
		.cmd       (q_cmd),
		.cmd_ready (back_ready),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.res_valid (res_valid),
		.res       (result),
		.pop       (pop)
	);

	`TCC_ASSERT_NEXT(a_push_lands, clk, arst_n, push && !full, !q_stat.empty)
	`TCC_ASSERT_NEXT(a_exec_lands, clk, arst_n, !q_stat.empty && back_ready, !empty)
	`TCC_ASSERT_NOW(a_no_draw_zero, clk, arst_n, !empty && !result.draw_valid, draw_clear)

endmodule

// File: sim/tb.sv
module tb;

	localparam logic [7:0]  HOME_COLUMN  = 8'd1;
	localparam logic [10:0] HOME_LINE    = 11'd8;
	localparam logic [10:0] ROW_STEP     = 11'd8;
	localparam logic [10:0] BOTTOM_ROOM  = 11'd16;
	localparam logic [6:0]  ERASE_GLYPH  = 7'h20;
	localparam logic [7:0]  TAB_STEP     = 8'd3;
	localparam int          STALL_LIMIT  = 2000;
	localparam int          RANDOM_PHASES = 6;
	localparam int          PHASE_ITEMS  = 325;

	logic          clk;
	logic          arst_n = 1'b0;
	logic          push = 1'b0;
	logic          full;
	tcc_pkg::in_t  item = '0;
	logic          empty;
	logic          pop = 1'b0;
	tcc_pkg::out_t result;
	logic          cfg_valid = 1'b0;
	logic          cfg_ready;
	logic          cfg_index = 1'b0;
	logic [10:0]   cfg_data = '0;

	// cursor and screen as the block should hold them
	logic [7:0]    screen_width = 8'd40;
	logic [10:0]   screen_height = 11'd240;
	logic [7:0]    cur_column = 8'd25;
	logic [10:0]   cur_line = 11'd32;

	tcc_pkg::in_t  item_backlog[$];
	tcc_pkg::out_t predicted_results[$];
	int            send_idle_pct = 0;
	int            recv_idle_pct = 0;
	int            mismatches = 0;
	int            stalled_cycles = 0;

	text_cursor_controller DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic logic bottom_scroll();
		logic [10:0] limit;
		limit = (screen_height >= BOTTOM_ROOM) ? screen_height - BOTTOM_ROOM : 11'd0;
		if (cur_line >= limit) begin
			cur_line = cur_line - ROW_STEP;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic logic advance_cursor();
		cur_column = cur_column + 8'd1;
		if (cur_column >= screen_width) begin
			cur_column = HOME_COLUMN;
			cur_line = cur_line + ROW_STEP;
		end
		return bottom_scroll();
	endfunction

	function automatic tcc_pkg::out_t cursor_step(tcc_pkg::in_t it);
		tcc_pkg::out_t o;
		logic [10:0] dy;
		o = '0;
		dy = {{3{it.move_offset[7]}}, it.move_offset};
		case (it.opcode)
			tcc_pkg::OP_SET: begin
				cur_column = it.set_column;
				cur_line = {it.set_row, 3'b000};
			end
			tcc_pkg::OP_MOVX: cur_column = cur_column + it.move_offset;
			tcc_pkg::OP_MOVY: cur_line = cur_line + (dy << 3);
			default: begin
				case (it.char_code)
					tcc_pkg::CH_NUL: ;
					tcc_pkg::CH_BS: begin
						if (cur_column != 8'd0)
							cur_column = cur_column - 8'd1;
						o.draw_valid = 1'b1;
						o.draw_column = cur_column;
						o.draw_line = cur_line;
						o.draw_glyph = ERASE_GLYPH;
					end
					tcc_pkg::CH_TAB: begin
						cur_column = cur_column + TAB_STEP;
						o.scroll_up = advance_cursor();
					end
					tcc_pkg::CH_LF, tcc_pkg::CH_CR, tcc_pkg::CH_VT: begin
						if (it.char_code != tcc_pkg::CH_VT)
							cur_column = HOME_COLUMN;
						cur_line = cur_line + ROW_STEP;
						o.scroll_up = bottom_scroll();
					end
					tcc_pkg::CH_FF: begin
						cur_column = HOME_COLUMN;
						cur_line = HOME_LINE;
					end
					tcc_pkg::CH_DEL: begin
						cur_column = cur_column + 8'd1;
						o.draw_valid = 1'b1;
						o.draw_column = cur_column;
						o.draw_line = cur_line;
						o.draw_glyph = ERASE_GLYPH;
					end
					default: begin
						o.draw_valid = 1'b1;
						o.draw_column = cur_column;
						o.draw_line = cur_line;
						o.draw_glyph = it.char_code;
						o.scroll_up = advance_cursor();
					end
				endcase
			end
		endcase
		o.cursor_column = cur_column;
		o.cursor_line = cur_line;
		return o;
	endfunction

	function automatic tcc_pkg::in_t make_item(logic [1:0] op, logic [6:0] ch, logic [7:0] col,
			logic [7:0] row, logic [7:0] off);
		tcc_pkg::in_t it;
		it.opcode = op;
		it.char_code = ch;
		it.set_column = col;
		it.set_row = row;
		it.move_offset = off;
		return it;
	endfunction

	function automatic tcc_pkg::in_t random_item();
		tcc_pkg::in_t it;
		int pick;
		it.char_code = 7'($urandom_range(127));
		it.set_column = 8'($urandom);
		it.set_row = 8'($urandom);
		it.move_offset = 8'($urandom);
		pick = $urandom_range(99);
		if (pick < 70) begin
			it.opcode = tcc_pkg::OP_CHAR;
			pick = $urandom_range(9);
			// mostly printable text, a good share of control codes
			if (pick < 5)
				it.char_code = 7'($urandom_range(32, 126));
			else if (pick < 8) begin
				case ($urandom_range(7))
					0: it.char_code = tcc_pkg::CH_NUL;
					1: it.char_code = tcc_pkg::CH_BS;
					2: it.char_code = tcc_pkg::CH_TAB;
					3: it.char_code = tcc_pkg::CH_LF;
					4: it.char_code = tcc_pkg::CH_VT;
					5: it.char_code = tcc_pkg::CH_FF;
					6: it.char_code = tcc_pkg::CH_CR;
					default: it.char_code = tcc_pkg::CH_DEL;
				endcase
			end
		end else if (pick < 80)
			it.opcode = tcc_pkg::OP_SET;
		else if (pick < 90)
			it.opcode = tcc_pkg::OP_MOVX;
		else
			it.opcode = tcc_pkg::OP_MOVY;
		return it;
	endfunction

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		$display("mismatch on %s: got %0h, expected %0h", what, got, want);
		mismatches++;
	endtask

	task automatic write_reg(input logic idx, input logic [10:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == tcc_pkg::REG_BYTES_PER_LINE)
			screen_width = data[7:0];
		else
			screen_height = data;
	endtask

	task automatic drain();
		while (item_backlog.size() != 0 || push || predicted_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// driver: one beat per accepted push
	always @(posedge clk) begin
		logic taken;
		taken = 1'b0;
		if (push && !full) begin
			predicted_results.push_back(cursor_step(item));
			taken = 1'b1;
		end
		if (!push || taken) begin
			if (item_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				item <= item_backlog.pop_front();
				push <= 1'b1;
			end else
				push <= 1'b0;
		end
	end

	// monitor: compare each popped beat against the oldest prediction
	always @(posedge clk) begin
		tcc_pkg::out_t want;
		if (pop && !empty) begin
			if (predicted_results.size() == 0)
				report_mismatch("unexpected result", 1, 0);
			else begin
				want = predicted_results.pop_front();
				if (result.draw_valid !== want.draw_valid)
					report_mismatch("draw_valid", result.draw_valid, want.draw_valid);
				if (result.draw_column !== want.draw_column)
					report_mismatch("draw_column", result.draw_column, want.draw_column);
				if (result.draw_line !== want.draw_line)
					report_mismatch("draw_line", result.draw_line, want.draw_line);
				if (result.draw_glyph !== want.draw_glyph)
					report_mismatch("draw_glyph", result.draw_glyph, want.draw_glyph);
				if (result.scroll_up !== want.scroll_up)
					report_mismatch("scroll_up", result.scroll_up, want.scroll_up);
				if (result.cursor_column !== want.cursor_column)
					report_mismatch("cursor_column", result.cursor_column, want.cursor_column);
				if (result.cursor_line !== want.cursor_line)
					report_mismatch("cursor_line", result.cursor_line, want.cursor_line);
			end
		end
		pop <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
			stalled_cycles <= 0;
		else
			stalled_cycles <= stalled_cycles + 1;
		if (stalled_cycles >= STALL_LIMIT) begin
			$display("text_cursor_controller regression: fail");
			$finish;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 36;
		recv_idle_pct = 46;

		// directed: every control code, clamps, wraps and scrolls at reset geometry
		item_backlog.push_back(make_item(tcc_pkg::OP_CHAR, tcc_pkg::CH_NUL, 0, 0, 0));
		item_backlog.push_back(make_item(tcc_pkg::OP_CHAR, 7'h41, 0, 0, 0));
		item_backlog.push_back(make_item(tcc_pkg::OP_CHAR, tcc_pkg::CH_BS, 0, 0, 0));
		item_backlog.push_back(make_item(tcc_pkg::OP_CHAR, tcc_pkg::CH_TAB, 0, 0, 0));
		item_backlog.push_back(make_item(tcc_pkg::OP_CHAR, tcc_pkg::CH_DEL, 0, 0, 0));
		item_backlog.push_back(make_item(tcc_pkg::OP_CHAR, tcc_pkg::CH_CR, 0, 0, 0));
		item_backlog.push_back(make_item(tcc_pkg::OP_CHAR, tcc_pkg::CH_LF, 0, 0, 0));
		item_backlog.push_back(make_item(tcc_pkg::OP_CHAR, tcc_pkg::CH_VT, 0, 0, 0));
		item_backlog.push_back(make_item(tcc_pkg::OP_CHAR, tcc_pkg::CH_FF, 0, 0, 0));
		item_backlog.push_back(make_item(tcc_pkg::OP_SET, 0, 8'd0, 8'd0, 0));
		item_backlog.push_back(make_item(tcc_pkg::OP_CHAR, tcc_pkg::CH_BS, 0, 0, 0));
		item_backlog.push_back(make_item(tcc_pkg::OP_CHAR, 7'h01, 0, 0, 0));
		item_backlog.push_back(make_item(tcc_pkg::OP_CHAR, 7'h7E, 0, 0, 0));
		item_backlog.push_back(make_item(tcc_pkg::OP_SET, 0, 8'd39, 8'd27, 0));
		item_backlog.push_back(make_item(tcc_pkg::OP_CHAR, 7'h5A, 0, 0, 0));
		item_backlog.push_back(make_item(tcc_pkg::OP_SET, 0, 8'd255, 8'd255, 0));
		item_backlog.push_back(make_item(tcc_pkg::OP_CHAR, tcc_pkg::CH_DEL, 0, 0, 0));
		item_backlog.push_back(make_item(tcc_pkg::OP_SET, 0, 8'd254, 8'd1, 0));
		item_backlog.push_back(make_item(tcc_pkg::OP_CHAR, tcc_pkg::CH_TAB, 0, 0, 0));
		item_backlog.push_back(make_item(tcc_pkg::OP_MOVX, 0, 0, 0, 8'h7F));
		item_backlog.push_back(make_item(tcc_pkg::OP_MOVX, 0, 0, 0, 8'h80));
		item_backlog.push_back(make_item(tcc_pkg::OP_MOVY, 0, 0, 0, 8'h7F));
		item_backlog.push_back(make_item(tcc_pkg::OP_MOVY, 0, 0, 0, 8'h80));
		item_backlog.push_back(make_item(tcc_pkg::OP_SET, 0, 8'd10, 8'd27, 0));
		item_backlog.push_back(make_item(tcc_pkg::OP_CHAR, tcc_pkg::CH_VT, 0, 0, 0));
		drain();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0: begin
					write_reg(tcc_pkg::REG_BYTES_PER_LINE, 11'd2);
					write_reg(tcc_pkg::REG_SCREEN_LINES, 11'd32);
				end
				1: begin
					write_reg(tcc_pkg::REG_BYTES_PER_LINE, 11'd255);
					write_reg(tcc_pkg::REG_SCREEN_LINES, 11'd2047);
				end
				3: begin
					write_reg(tcc_pkg::REG_BYTES_PER_LINE, 11'd40);
					write_reg(tcc_pkg::REG_SCREEN_LINES, 11'd240);
				end
				default: begin
					write_reg(tcc_pkg::REG_BYTES_PER_LINE, 11'($urandom_range(2, 255)));
					write_reg(tcc_pkg::REG_SCREEN_LINES, 11'($urandom_range(32, 2047)));
				end
			endcase
			if (p < 2) begin
				send_idle_pct = 36;
				recv_idle_pct = 46;
			end else if (p < 4) begin
				send_idle_pct = 46;
				recv_idle_pct = 36;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			for (int n = 0; n < PHASE_ITEMS; n++)
				item_backlog.push_back(random_item());
			drain();
		end

		if (mismatches == 0)
			$display("text_cursor_controller regression: pass");
		else
			$display("text_cursor_controller regression: fail");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/tcc_pkg.sv
rtl/core/tcc_front.sv
rtl/core/tcc_queue.sv
rtl/core/tcc_back.sv
rtl/core/text_cursor_controller.sv
sim/tb.sv
